[design/hex_record_parser_macros.svh]
// ---------------------------------------------------------------------------
// hex_record_parser assertion macros
// shared assertion forms for the record parser checks
// ---------------------------------------------------------------------------
`ifndef HEX_RECORD_PARSER_MACROS_SVH
`define HEX_RECORD_PARSER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define HRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define HRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/hrp_pkg.sv]
// ---------------------------------------------------------------------------
// hrp_pkg
// shared types and character constants of the hex record parser
// ---------------------------------------------------------------------------
package hrp_pkg;

  localparam logic [7:0] CharColon = 8'h3A;  // ':'
  localparam logic [7:0] CharZero  = 8'h30;  // '0'
  localparam logic [7:0] CharNine  = 8'h39;  // '9'
  localparam logic [7:0] CharLowA  = 8'h61;  // 'a'
  localparam logic [7:0] CharLowF  = 8'h66;  // 'f'
  localparam logic [7:0] CharUpA   = 8'h41;  // 'A'
  localparam logic [7:0] CharUpF   = 8'h46;  // 'F'
  localparam logic [3:0] NibTen    = 4'd10;

  // decoded hex digit
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } nibble_t;

endpackage

[design/hrp_nib_dec.sv]
// ---------------------------------------------------------------------------
// hrp_nib_dec
// ascii hex digit decoder, upper and lower case
// ---------------------------------------------------------------------------
module hrp_nib_dec (
  input  logic [7:0]       char_i,
  output hrp_pkg::nibble_t nib_o
);

  logic [7:0] off_digit;
  logic [7:0] off_lower;
  logic [7:0] off_upper;

  assign off_digit = char_i - hrp_pkg::CharZero;
  assign off_lower = char_i - hrp_pkg::CharLowA;
  assign off_upper = char_i - hrp_pkg::CharUpA;

  always_comb begin
    nib_o.ok  = 1'b0;
    nib_o.val = 4'd0;
    if (char_i >= hrp_pkg::CharZero && char_i <= hrp_pkg::CharNine) begin
      nib_o.ok  = 1'b1;
      nib_o.val = off_digit[3:0];
    end else if (char_i >= hrp_pkg::CharLowA && char_i <= hrp_pkg::CharLowF) begin
      nib_o.ok  = 1'b1;
      nib_o.val = off_lower[3:0] + hrp_pkg::NibTen;
    end else if (char_i >= hrp_pkg::CharUpA && char_i <= hrp_pkg::CharUpF) begin
      nib_o.ok  = 1'b1;
      nib_o.val = off_upper[3:0] + hrp_pkg::NibTen;
    end
  end

endmodule

[design/hex_record_parser.sv]
// ---------------------------------------------------------------------------
// hex_record_parser
// parses one intel hex data record per line, one character per transfer
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | sink      | in_valid_i / in_stall_o | char_code_i, line_end_i
//  out     | source    | out_valid_o/out_stall_i | kind_o, byte_address_o,
//          |           |                         | data_byte_o, record_count_o,
//          |           |                         | record_error_o, is_last_o
//
// one character per cycle sustained while out is not stalled; a character is held
// in the input register and its result is then held in the result register
// the parse logic (nibble decode, 8-bit checksum add, address add) sits
// between the input register and the result register
// rst_ni clears all parser state, both valid flags and returns to expect colon
// a stall on out holds the result register and, while it is full, the input
// register; in_stall_o rises only when the input register cannot move on
// ---------------------------------------------------------------------------
`include "hex_record_parser_macros.svh"

module hex_record_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        line_end_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [15:0] byte_address_o,
  output logic [7:0]  data_byte_o,
  output logic [7:0]  record_count_o,
  output logic        record_error_o,
  output logic        is_last_o
);

  // field being parsed
  typedef enum logic [2:0] {
    PH_COLON,
    PH_COUNT,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_TYPE,
    PH_DATA,
    PH_CHECK,
    PH_DONE
  } phase_e;

  // input register
  logic       in_vld_q;
  logic [7:0] char_q;
  logic       last_q;

  // parser state
  phase_e      phase_q, phase_d;
  logic [3:0]  high_q, high_d;
  logic        half_q, half_d;
  logic [7:0]  count_q, count_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  index_q, index_d;
  logic [7:0]  sum_q, sum_d;
  logic        failed_q, failed_d;
  logic        complete_q, complete_d;

  // result register
  logic        out_vld_q;
  logic        kind_q, kind_d;
  logic [15:0] baddr_q, baddr_d;
  logic [7:0]  dbyte_q, dbyte_d;
  logic [7:0]  rcount_q, rcount_d;
  logic        rerr_q, rerr_d;
  logic        rlast_q, rlast_d;
  logic        has_res;

  logic             adv;        // input register hands its character on
  logic             in_take;    // input transfer
  hrp_pkg::nibble_t nib;
  logic [7:0]       byte_v;
  logic [7:0]       idx_next;

  hrp_nib_dec u_nib_dec (
    .char_i (char_q),
    .nib_o  (nib)
  );

  // the result register is free when empty or being drained this cycle
  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  assign byte_v   = {high_q, nib.val};
  assign idx_next = index_q + 8'd1;

  // parse one character
  always_comb begin
    phase_d    = phase_q;
    high_d     = high_q;
    half_d     = half_q;
    count_d    = count_q;
    addr_d     = addr_q;
    index_d    = index_q;
    sum_d      = sum_q;
    failed_d   = failed_q;
    complete_d = complete_q;
    has_res    = 1'b0;
    kind_d     = 1'b0;
    baddr_d    = 16'd0;
    dbyte_d    = 8'd0;
    rcount_d   = 8'd0;
    rerr_d     = 1'b0;
    rlast_d    = 1'b0;

    // nothing more is parsed once the record has failed or completed
    if (!failed_q && !complete_q) begin
      if (phase_q == PH_COLON) begin
        if (char_q != hrp_pkg::CharColon) begin
          failed_d = 1'b1;
        end else begin
          phase_d = PH_COUNT;
        end
      end else if (!nib.ok) begin
        failed_d = 1'b1;
      end else if (!half_q) begin
        high_d = nib.val;
        half_d = 1'b1;
      end else begin
        half_d = 1'b0;
        sum_d  = sum_q + byte_v;
        case (phase_q)
          PH_COUNT: begin
            count_d = byte_v;
            phase_d = PH_ADDR_HI;
          end
          PH_ADDR_HI: begin
            addr_d  = {byte_v, 8'd0};
            phase_d = PH_ADDR_LO;
          end
          PH_ADDR_LO: begin
            addr_d  = {addr_q[15:8], byte_v};
            phase_d = PH_TYPE;
          end
          PH_TYPE: begin
            // only data records are accepted
            if (byte_v != 8'd0) begin
              failed_d = 1'b1;
            end else if (count_q == 8'd0) begin
              phase_d = PH_CHECK;
            end else begin
              phase_d = PH_DATA;
            end
          end
          PH_DATA: begin
            has_res  = 1'b1;
            baddr_d  = addr_q + {8'd0, index_q};
            dbyte_d  = byte_v;
            rcount_d = count_q;
            index_d  = idx_next;
            if (idx_next == count_q) begin
              phase_d = PH_CHECK;
            end
          end
          default: begin
            // checksum byte: all bytes of the record must sum to zero
            if (sum_d != 8'd0) begin
              failed_d = 1'b1;
            end else begin
              complete_d = 1'b1;
            end
            phase_d = PH_DONE;
          end
        endcase
      end
    end

    // end of line: status replaces any data byte and the parser starts over
    if (last_q) begin
      has_res    = 1'b1;
      kind_d     = 1'b1;
      baddr_d    = addr_d;
      dbyte_d    = 8'd0;
      rcount_d   = count_d;
      rerr_d     = failed_d || !complete_d;
      rlast_d    = 1'b1;
      phase_d    = PH_COLON;
      high_d     = 4'd0;
      half_d     = 1'b0;
      count_d    = 8'd0;
      addr_d     = 16'd0;
      index_d    = 8'd0;
      sum_d      = 8'd0;
      failed_d   = 1'b0;
      complete_d = 1'b0;
    end
  end

  // input register, parser state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      phase_q    <= PH_COLON;
      high_q     <= 4'd0;
      half_q     <= 1'b0;
      count_q    <= 8'd0;
      addr_q     <= 16'd0;
      index_q    <= 8'd0;
      sum_q      <= 8'd0;
      failed_q   <= 1'b0;
      complete_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        phase_q    <= phase_d;
        high_q     <= high_d;
        half_q     <= half_d;
        count_q    <= count_d;
        addr_q     <= addr_d;
        index_q    <= index_d;
        sum_q      <= sum_d;
        failed_q   <= failed_d;
        complete_q <= complete_d;
        out_vld_q  <= has_res;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q <= char_code_i;
      last_q <= line_end_i;
    end
    if (adv && has_res) begin
      kind_q   <= kind_d;
      baddr_q  <= baddr_d;
      dbyte_q  <= dbyte_d;
      rcount_q <= rcount_d;
      rerr_q   <= rerr_d;
      rlast_q  <= rlast_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign kind_o         = kind_q;
  assign byte_address_o = baddr_q;
  assign data_byte_o    = dbyte_q;
  assign record_count_o = rcount_q;
  assign record_error_o = rerr_q;
  assign is_last_o      = rlast_q;

  // checks
  `HRP_ASSERT_NOW(a_data_clean, out_vld_q && !kind_q, !rerr_q && !rlast_q, "bad data flags")
  `HRP_ASSERT_NOW(a_status_zero, out_vld_q && kind_q, rlast_q && dbyte_q == 8'd0, "bad status")
  `HRP_ASSERT_NOW(a_fail_done, 1'b1, !(failed_q && complete_q), "failed and complete")
  `HRP_ASSERT_NEXT(a_line_restart, adv && last_q, !half_q && phase_q == PH_COLON, "no restart")

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// hex_record_parser testbench
// feeds record lines one character per transfer, with random gaps on both
// channels, and checks every result against an in-bench parser of its own
// ---------------------------------------------------------------------------

package hrp_check_pkg;

  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef enum logic [2:0] {
    ExpectColon, CountField, AddrHigh, AddrLow, TypeField, DataField, CheckField, LineDone
  } parse_phase_e;

  typedef struct packed {
    logic        kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  count;
    logic        err;
    logic        last;
  } parse_result_t;

  function automatic hrp_pkg::nibble_t decode_digit(logic [7:0] c);
    hrp_pkg::nibble_t n;
    n.ok  = 1'b1;
    n.val = 4'd0;
    if (c >= hrp_pkg::CharZero && c <= hrp_pkg::CharNine) begin
      n.val = 4'(c - hrp_pkg::CharZero);
    end else if (c >= hrp_pkg::CharLowA && c <= hrp_pkg::CharLowF) begin
      n.val = 4'(c - hrp_pkg::CharLowA) + hrp_pkg::NibTen;
    end else if (c >= hrp_pkg::CharUpA && c <= hrp_pkg::CharUpF) begin
      n.val = 4'(c - hrp_pkg::CharUpA) + hrp_pkg::NibTen;
    end else begin
      n.ok = 1'b0;
    end
    return n;
  endfunction

  class hex_line_tracker;
    parse_phase_e  phase;
    logic [3:0]    high_nib;
    logic          half;
    logic [7:0]    count;
    logic [7:0]    index;
    logic [7:0]    csum;
    logic [15:0]   base_addr;
    logic          failed;
    logic          complete;
    parse_result_t due_results[$];
    int unsigned   errors, checked, good_lines, bad_lines, data_seen, parsed_chars;

    function new();
      clear_line();
      errors = 0;
      checked = 0;
      good_lines = 0;
      bad_lines = 0;
      data_seen = 0;
      parsed_chars = 0;
    endfunction

    function void clear_line();
      phase     = ExpectColon;
      high_nib  = 4'd0;
      half      = 1'b0;
      count     = 8'd0;
      index     = 8'd0;
      csum      = 8'd0;
      base_addr = 16'd0;
      failed    = 1'b0;
      complete  = 1'b0;
    endfunction

    function int unsigned outstanding();
      return due_results.size();
    endfunction

    function void accept_char(logic [7:0] c, logic le);
      hrp_pkg::nibble_t d;
      logic [7:0]       b;
      logic             got_data;
      parse_result_t    r;
      got_data = 1'b0;
      r = '0;
      if (!failed && !complete) begin
        parsed_chars++;
        if (phase == ExpectColon) begin
          if (c != hrp_pkg::CharColon) failed = 1'b1;
          else phase = CountField;
        end else begin
          d = decode_digit(c);
          if (!d.ok) begin
            failed = 1'b1;
          end else if (!half) begin
            high_nib = d.val;
            half = 1'b1;
          end else begin
            b = {high_nib, d.val};
            half = 1'b0;
            csum = csum + b;
            case (phase)
              CountField: begin
                count = b;
                phase = AddrHigh;
              end
              AddrHigh: begin
                base_addr = {b, 8'h00};
                phase = AddrLow;
              end
              AddrLow: begin
                base_addr[7:0] = b;
                phase = TypeField;
              end
              TypeField: begin
                if (b != 8'd0) failed = 1'b1;
                else phase = (count == 8'd0) ? CheckField : DataField;
              end
              DataField: begin
                got_data = 1'b1;
                r.kind  = KindData;
                r.addr  = base_addr + {8'h00, index};
                r.data  = b;
                index = index + 8'd1;
                if (index == count) phase = CheckField;
              end
              default: begin
                if (csum != 8'd0) failed = 1'b1;
                else complete = 1'b1;
                phase = LineDone;
              end
            endcase
          end
        end
      end else if (le) begin
        parsed_chars++;
      end

      if (le) begin
        // a byte completed by the closing character is dropped, only status goes out
        r.kind  = KindStatus;
        r.addr  = base_addr;
        r.data  = 8'd0;
        r.count = count;
        r.err   = failed || !complete;
        r.last  = 1'b1;
        if (r.err) bad_lines++;
        else good_lines++;
        due_results.push_back(r);
        clear_line();
      end else if (got_data) begin
        r.count = count;
        r.err   = 1'b0;
        r.last  = 1'b0;
        due_results.push_back(r);
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void compare_output(parse_result_t got);
      parse_result_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing expected: kind %0d addr 0x%0h", got.kind, got.addr);
        errors++;
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (want.kind == KindData) data_seen++;
      compare_field("kind", 16'(want.kind), 16'(got.kind));
      compare_field("byte_address", want.addr, got.addr);
      compare_field("data_byte", 16'(want.data), 16'(got.data));
      compare_field("record_count", 16'(want.count), 16'(got.count));
      compare_field("record_error", 16'(want.err), 16'(got.err));
      compare_field("is_last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

endpackage

module testbench;

  localparam int unsigned CharTarget  = 1700;  // minimum characters sent in all
  localparam int unsigned HoldCycles  = 120;   // long receiver hold-off
  localparam int unsigned SettleTicks = 20;    // latency allowance after the last result

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  char_code_i;
  logic        line_end_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        kind_o;
  logic [15:0] byte_address_o;
  logic [7:0]  data_byte_o;
  logic [7:0]  record_count_o;
  logic        record_error_o;
  logic        is_last_o;

  hrp_check_pkg::hex_line_tracker tracker;

  // characters of the line being sent
  logic [7:0]  line_chars[$];
  int unsigned lines_sent;
  int unsigned chars_sent;
  int unsigned big_left;

  // pacing controls shared between the sender, the receiver and the main flow
  logic        steady_sender;
  logic        steady_receiver;
  logic        hold_request;
  logic        hold_active;

  hex_record_parser DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .line_end_i     (line_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .byte_address_o (byte_address_o),
    .data_byte_o    (data_byte_o),
    .record_count_o (record_count_o),
    .record_error_o (record_error_o),
    .is_last_o      (is_last_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // character generation
  // ---------------------------------------------------------------------------

  // hex digit in a random case
  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < hrp_pkg::NibTen) return hrp_pkg::CharZero + 8'(v);
    return ($urandom_range(0, 1) ? hrp_pkg::CharUpA : hrp_pkg::CharLowA)
           + 8'(v - hrp_pkg::NibTen);
  endfunction

  function automatic logic [7:0] draw_non_hex();
    logic [7:0]       c;
    hrp_pkg::nibble_t d;
    do begin
      c = 8'($urandom);
      d = hrp_check_pkg::decode_digit(c);
    end while (d.ok);
    return c;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    line_chars.push_back(hex_char(b[7:4]));
    line_chars.push_back(hex_char(b[3:0]));
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_chars.push_back(8'(s[i]));
  endtask

  // half well-formed records with random content; the rest are broken on purpose
  task automatic build_random_line();
    int unsigned pick;
    int unsigned keep;
    logic [7:0]  cnt, sum, typ, csum, b;
    logic [15:0] base;
    logic [7:0]  bad;
    pick = $urandom_range(0, 99);
    if (big_left != 0 && $urandom_range(0, 49) == 0) begin
      cnt = 8'($urandom_range(17, 255));
      big_left--;
    end else begin
      cnt = 8'($urandom_range(0, 16));
    end
    // some records start near the top of the address space so the data address wraps
    if ($urandom_range(0, 4) == 0) base = 16'hFFFF - 16'($urandom_range(0, 12));
    else base = 16'($urandom);
    typ = (pick >= 60 && pick < 68) ? 8'($urandom_range(1, 255)) : 8'd0;

    line_chars.delete();
    line_chars.push_back(hrp_pkg::CharColon);
    sum = cnt + base[15:8] + base[7:0] + typ;
    push_byte(cnt);
    push_byte(base[15:8]);
    push_byte(base[7:0]);
    push_byte(typ);
    for (int i = 0; i < int'(cnt); i++) begin
      b = 8'($urandom);
      sum = sum + b;
      push_byte(b);
    end
    csum = 8'd0 - sum;
    if (pick >= 50 && pick < 60) csum = csum ^ 8'($urandom_range(1, 255));
    push_byte(csum);

    if (pick >= 68 && pick < 76) begin
      // bad start
      do bad = 8'($urandom); while (bad == hrp_pkg::CharColon);
      line_chars[0] = bad;
    end else if (pick >= 76 && pick < 84) begin
      // stray non-hex character somewhere in the digits
      line_chars[$urandom_range(1, line_chars.size() - 1)] = draw_non_hex();
    end

    if (pick >= 84) begin
      // truncated line, possibly ending on a completed data byte
      keep = $urandom_range(1, line_chars.size() - 1);
      while (line_chars.size() > keep) void'(line_chars.pop_back());
    end else if ($urandom_range(0, 3) == 0) begin
      // trailing rubbish that the parser must ignore
      repeat ($urandom_range(1, 4)) line_chars.push_back(8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender: one character per transfer, random gap before each
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic le);
    int unsigned gap;
    gap = (steady_sender || hold_active) ? 0 : $urandom_range(0, 15);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    line_end_i  <= le;
    do @(posedge clk_i); while (in_stall_o);
    chars_sent++;
    tracker.accept_char(c, le);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_chars.size(); i++)
      send_char(line_chars[i], i == line_chars.size() - 1);
    lines_sent++;
  endtask

  // drop valid first so the last character is not offered again
  task automatic wait_for_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall before each result, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    hrp_check_pkg::parse_result_t got;
    int unsigned                  pause;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        // the sender keeps offering characters meanwhile, so the block backs up
        hold_request = 1'b0;
        hold_active  = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_active  = 1'b0;
        out_stall_i <= 1'b0;
      end else begin
        if ($urandom_range(0, 19) == 0) steady_receiver = !steady_receiver;
        pause = steady_receiver ? 0 : $urandom_range(0, 15);
        if (pause != 0) begin
          out_stall_i <= 1'b1;
          repeat (pause) @(negedge clk_i);
        end
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      got.kind  = kind_o;
      got.addr  = byte_address_o;
      got.data  = data_byte_o;
      got.count = record_count_o;
      got.err   = record_error_o;
      got.last  = is_last_o;
      tracker.compare_output(got);
    end
  end

  // ---------------------------------------------------------------------------
  // main flow
  // ---------------------------------------------------------------------------
  initial begin
    logic hold_issued;
    logic drain_issued;
    in_valid_i      = 1'b0;
    char_code_i     = 8'd0;
    line_end_i      = 1'b0;
    out_stall_i     = 1'b0;
    rst_ni          = 1'b0;
    steady_sender   = 1'b0;
    steady_receiver = 1'b0;
    hold_request    = 1'b0;
    hold_active     = 1'b0;
    hold_issued     = 1'b0;
    drain_issued    = 1'b0;
    lines_sent      = 0;
    chars_sent      = 0;
    big_left        = 3;
    tracker = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed lines
    // bad start on the lowest character code
    line_chars.delete();
    line_chars.push_back(8'h00);
    send_line();
    // colon then the highest character code where a digit is due
    line_chars.delete();
    line_chars.push_back(hrp_pkg::CharColon);
    line_chars.push_back(8'hFF);
    send_line();
    // zero count at the top address, lower-case digits, good checksum
    line_chars.delete();
    push_text(":00ffff0002");
    send_line();
    // nonzero type, line ends on the type byte
    line_chars.delete();
    push_text(":00000001");
    send_line();
    wait_for_drain();

    // random lines
    while (chars_sent < CharTarget) begin
      if (!hold_issued && chars_sent >= 500) begin
        hold_request = 1'b1;
        hold_issued  = 1'b1;
      end
      if (!drain_issued && chars_sent >= 1100) begin
        // sender stands back until every result is out
        wait_for_drain();
        drain_issued = 1'b1;
      end
      steady_sender = ($urandom_range(0, 3) == 0);
      build_random_line();
      send_line();
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    wait_for_drain();
    repeat (SettleTicks) @(posedge clk_i);

    $display("%0d lines, %0d characters sent, %0d parsed: %0d records accepted, %0d rejected",
             lines_sent, chars_sent, tracker.parsed_chars, tracker.good_lines,
             tracker.bad_lines);
    $display("%0d results checked, %0d of them data bytes", tracker.checked,
             tracker.data_seen);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("PASS hex_record_parser");
    end else begin
      $display("FAIL hex_record_parser");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAIL hex_record_parser");
    $finish;
  end

endmodule
